// ===== rtl/lrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants for the longest-remaining-time scheduler
// Field widths, the sequencer state encoding, and the structs that run between
// the process table, the selection unit and the top level.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int MAX_PROCESSES_DEF = 16;
  localparam int ID_W              = 8;
  localparam int TIME_W            = 16;

  // Operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  // Table write request: a load fills a whole slot, a decrement touches
  // only the remaining time.
  typedef struct packed {
    logic              load_en;
    logic              dec_en;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] remaining;
  } table_wr_t;

  // One slot as read back from the table during a scan
  typedef struct packed {
    logic              vld;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] remaining;
  } slot_rd_t;

endpackage

// ===== rtl/lrt_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_table: process table memory
// Holds id, arrival time and remaining time per slot. One write port, one
// read port with registered read data.
// ----------------------------------------------------------------------------
module lrt_table import lrt_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1
) (
  input  logic             clk,
  input  table_wr_t        wr,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [ID_W-1:0]   rd_id,
  output logic [TIME_W-1:0] rd_arrival,
  output logic [TIME_W-1:0] rd_remaining
);

  logic [ID_W-1:0]   id_mem  [MAX_PROCESSES];
  logic [TIME_W-1:0] arr_mem [MAX_PROCESSES];
  logic [TIME_W-1:0] rem_mem [MAX_PROCESSES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr.load_en) begin
      id_mem[wr_addr]  <= wr.id;
      arr_mem[wr_addr] <= wr.arrival;
    end
    if (wr.load_en || wr.dec_en) begin
      rem_mem[wr_addr] <= wr.remaining;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_id        <= id_mem[rd_addr];
    rd_arrival   <= arr_mem[rd_addr];
    rd_remaining <= rem_mem[rd_addr];
  end

endmodule

// ===== rtl/lrt_pick.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pick: shared selection unit
// Takes one slot per cycle, keeps the eligible slot with the largest
// remaining time (first one wins a tie) and counts slots with work left.
// ----------------------------------------------------------------------------
module lrt_pick import lrt_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF,
  parameter int IDX_W         = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
  parameter int CNT_W         = $clog2(MAX_PROCESSES + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic [TIME_W-1:0] now,
  input  slot_rd_t          smp,
  input  logic [IDX_W-1:0]  smp_idx,
  output logic              found,
  output logic [TIME_W-1:0] best,
  output logic [IDX_W-1:0]  pick_idx,
  output logic [ID_W-1:0]   best_id,
  output logic [CNT_W-1:0]  nz_cnt
);

  logic eligible;
  logic take;

  // One compare chain: eligibility, then larger-than-best
  assign eligible = (smp.arrival <= now) && (smp.remaining != '0);
  assign take     = smp.vld && eligible && (!found || (smp.remaining > best));

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      found  <= 1'b0;
      nz_cnt <= '0;
    end else begin
      if (take) begin
        found <= 1'b1;
      end
      if (smp.vld && (smp.remaining != '0)) begin
        nz_cnt <= nz_cnt + CNT_W'(1);
      end
    end
  end

  // Winner payload
  always_ff @(posedge clk) begin
    if (take) begin
      best     <= smp.remaining;
      pick_idx <= smp_idx;
      best_id  <= smp.id;
    end
  end

endmodule

// ===== rtl/longest_remaining_time_scheduler_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// longest_remaining_time_scheduler_top: preemptive LRTF scheduler
// A load transaction (operation = 0) stores a process in the next free slot
// and gives no result; a full table ignores it. A tick transaction
// (operation = 1) picks, among arrived processes with work left, the one with
// the most remaining time (lowest slot on a tie), runs it for one tick and
// returns one result transaction: the tick time, busy flag, chosen id,
// new-segment flag and all-done flag. Idle ticks only advance time, which
// saturates at its maximum.
// A load is written into the table as it is accepted. A tick runs from acceptance
// through the SCAN and FINISH states to out_valid: the sequencer walks the loaded
// slots one per cycle through the single table read port into one comparator.
// in_ready is high only while the sequencer is idle.
// The result sits in an output register; the next transaction may be taken
// while it waits. A tick that finishes while the receiver stalls holds until
// the output register frees.
// Reset clears slot count, time, last-run id and the handshake state; table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module longest_remaining_time_scheduler_top import lrt_pkg::*; #(
  parameter int MAX_PROCESSES = MAX_PROCESSES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              operation,
  input  logic [ID_W-1:0]   process_id,
  input  logic [TIME_W-1:0] arrival_time,
  input  logic [TIME_W-1:0] burst_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [TIME_W-1:0] tick_time,
  output logic              busy_res,
  output logic [ID_W-1:0]   chosen_id,
  output logic              new_segment,
  output logic              all_done
);

  localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

  state_t state, state_next;

  logic [CNT_W-1:0]  slot_count;
  logic [TIME_W-1:0] current_tick;
  logic [ID_W-1:0]   last_run_id;
  logic              have_last_run;

  logic [CNT_W-1:0]  scan_addr;
  logic              issue;
  logic              issue_d;
  logic [IDX_W-1:0]  idx_d;

  logic in_fire, out_fire, load_fire, tick_fire, out_free, finish_go;
  logic table_full;

  table_wr_t         wr;
  logic [IDX_W-1:0]  wr_addr;
  logic [ID_W-1:0]   rd_id;
  logic [TIME_W-1:0] rd_arrival;
  logic [TIME_W-1:0] rd_remaining;
  slot_rd_t          smp;

  logic              found;
  logic [TIME_W-1:0] best;
  logic [IDX_W-1:0]  pick_idx;
  logic [ID_W-1:0]   best_id;
  logic [CNT_W-1:0]  nz_cnt;
  logic              done_now;

  // Handshake decode
  assign in_ready   = (state == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_fire   = out_valid && out_ready;
  assign load_fire  = in_fire && (operation == OP_LOAD);
  assign tick_fire  = in_fire && (operation == OP_TICK);
  assign out_free   = !out_valid || out_ready;
  assign finish_go  = (state == ST_FINISH) && out_free;
  assign table_full = (slot_count == CNT_W'(MAX_PROCESSES));

  // Scan issue: one slot address per cycle
  assign issue = (state == ST_SCAN) && (scan_addr < slot_count);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (tick_fire) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (!issue && !issue_d) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_addr <= '0;
      issue_d   <= 1'b0;
    end else begin
      state   <= state_next;
      issue_d <= issue;
      if (tick_fire) begin
        scan_addr <= '0;
      end else if (issue) begin
        scan_addr <= scan_addr + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_d <= scan_addr[IDX_W-1:0];
  end

  // Table write: load fills a slot, finish decrements the winner
  always_comb begin
    wr.load_en   = load_fire && !table_full;
    wr.dec_en    = finish_go && found;
    wr.id        = process_id;
    wr.arrival   = arrival_time;
    wr.remaining = wr.load_en ? burst_length : (best - TIME_W'(1));
    wr_addr      = wr.load_en ? slot_count[IDX_W-1:0] : pick_idx;
  end

  lrt_table #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .IDX_W         (IDX_W)
  ) u_table (
    .clk          (clk),
    .wr           (wr),
    .wr_addr      (wr_addr),
    .rd_addr      (scan_addr[IDX_W-1:0]),
    .rd_id        (rd_id),
    .rd_arrival   (rd_arrival),
    .rd_remaining (rd_remaining)
  );

  assign smp = '{vld: issue_d, id: rd_id, arrival: rd_arrival, remaining: rd_remaining};

  lrt_pick #(
    .MAX_PROCESSES (MAX_PROCESSES),
    .IDX_W         (IDX_W),
    .CNT_W         (CNT_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .clear    (tick_fire),
    .now      (current_tick),
    .smp      (smp),
    .smp_idx  (idx_d),
    .found    (found),
    .best     (best),
    .pick_idx (pick_idx),
    .best_id  (best_id),
    .nz_cnt   (nz_cnt)
  );

  // Done after this tick: nothing left, or only the winner with its last tick
  assign done_now = (nz_cnt == '0) ||
                    (found && (nz_cnt == CNT_W'(1)) && (best == TIME_W'(1)));

  // Scheduler state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count    <= '0;
      current_tick  <= '0;
      last_run_id   <= '0;
      have_last_run <= 1'b0;
    end else begin
      if (wr.load_en) begin
        slot_count <= slot_count + CNT_W'(1);
      end
      if (finish_go) begin
        if (current_tick != '1) begin
          current_tick <= current_tick + TIME_W'(1);
        end
        if (found) begin
          last_run_id   <= best_id;
          have_last_run <= 1'b1;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish_go) begin
      out_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish_go) begin
      tick_time   <= current_tick;
      busy_res    <= found;
      chosen_id   <= found ? best_id : '0;
      new_segment <= found && (!have_last_run || (last_run_id != best_id));
      all_done    <= done_now;
    end
  end

  // Checks
  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    tick_fire |=> (state == ST_SCAN))
    else $error("tick transaction did not start a scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (scan_addr <= slot_count))
    else $error("scan address ran past slot count");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= CNT_W'(MAX_PROCESSES))
    else $error("slot count exceeds table depth");

  a_idle_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !busy_res) |-> ((chosen_id == '0) && !new_segment))
    else $error("idle tick reported a process");

endmodule
